FILE: hw/rtl/fsic_pkg.sv
`default_nettype none
package fsic_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int RADIUS_BITS = 16;

  localparam int IN_W  = ((6 * COORD_BITS + 7) / 8) * 8;
  localparam int OV_W  = FRAC_BITS + 1;
  localparam int OUT_W = ((2 * OV_W + 7) / 8) * 8;
  localparam int ST_W  = 2;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [ST_W-1:0] ST_INTERVAL = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE     = 2'd1;
  localparam logic [ST_W-1:0] ST_SINGLE   = 2'd2;
  localparam logic [ST_W-1:0] ST_ZERO_LEN = 2'd3;

  localparam logic REG_RADIUS = 1'b0;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(1);

endpackage
`default_nettype wire

FILE: hw/rtl/free_space_interval_calc.sv
`default_nettype none
// Channel   Dir  Handshake          Contents
// in_       in   tvalid/tready      segment start, segment end, query point
// out_      out  tvalid/tready      interval start and end, status in tuser
// cfg       in   APB write/read     radius register at byte address 0
// One transaction is accepted per cycle; the pipeline is 57 stages deep at the
// default widths: six stages of products and sums, one square-root stage per result
// bit (33), one setup stage and one stage per fraction bit (16) of the two dividers,
// and the output register.
// When a result waits at the output, the whole pipeline holds and in_tready falls.
// Reset clears the valid bits and sets the radius to one.
module free_space_interval_calc (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, point_x, point_y
  input  logic [fsic_pkg::IN_W-1:0]        in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // interval_start, interval_end
  output logic [fsic_pkg::OUT_W-1:0]       out_tdata,
  // status
  output logic [fsic_pkg::ST_W-1:0]        out_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fsic_pkg::CFG_AW-1:0]      paddr,
  input  logic [fsic_pkg::CFG_DW-1:0]      pwdata,
  output logic [fsic_pkg::CFG_DW-1:0]      prdata,
  output logic                             pready
);

  localparam int CB     = fsic_pkg::COORD_BITS;
  localparam int FB     = fsic_pkg::FRAC_BITS;
  localparam int RB     = fsic_pkg::RADIUS_BITS;
  localparam int OV_W   = fsic_pkg::OV_W;
  localparam int OUT_W  = fsic_pkg::OUT_W;
  localparam int ST_W   = fsic_pkg::ST_W;
  localparam int DW     = CB + 1;
  localparam int P_W    = 2 * DW;
  localparam int DEN_W  = 2 * CB + 1;
  localparam int B_W    = 2 * DW;
  localparam int CW     = 2 * CB + 1;
  localparam int CL     = (CW + 1) / 2;
  localparam int CH     = CW - CL;
  localparam int DL     = (DEN_W + 1) / 2;
  localparam int DH     = DEN_W - DL;
  localparam int RR_W   = 2 * RB + DEN_W;
  localparam int CC_W   = 2 * CW;
  localparam int MW     = (RR_W > CC_W) ? RR_W : CC_W;
  localparam int SQ_W   = (RR_W + 1) / 2;
  localparam int RAD_W  = 2 * SQ_W;
  localparam int REM_W  = SQ_W + 2;
  localparam int N_W    = B_W + 1;

  typedef struct packed {
    logic signed [B_W-1:0] b;
    logic [DEN_W-1:0]      den;
    logic [ST_W-1:0]       st;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [SQ_W-1:0]  q;
    logic [RAD_W-1:0] rad;
  } sq_t;

  typedef struct packed {
    logic             fix;
    logic [OV_W-1:0]  fval;
    logic [DEN_W-1:0] rem;
    logic [FB-1:0]    q;
  } dv_t;

  function automatic sq_t sq_step(input sq_t s);
    sq_t             o;
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    cur   = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = {s.q, 2'b01};
    o.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      o.rem = cur - trial;
      o.q   = {s.q[SQ_W-2:0], 1'b1};
    end else begin
      o.rem = cur;
      o.q   = {s.q[SQ_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_t dv_init(input logic signed [N_W-1:0] n, input logic [DEN_W-1:0] den);
    dv_t o;
    o.q    = '0;
    o.rem  = '0;
    o.fix  = 1'b1;
    o.fval = '0;
    if (n[N_W-1] || (n == '0)) begin
      o.fval = '0;
    end else if ($unsigned(n) >= N_W'(den)) begin
      o.fval = OV_W'(1) << FB;
    end else begin
      o.fix = 1'b0;
      o.rem = n[DEN_W-1:0];
    end
    return o;
  endfunction

  function automatic dv_t dv_step(input dv_t s, input logic [DEN_W-1:0] den);
    dv_t            o;
    logic [DEN_W:0] r2;
    o  = s;
    r2 = {s.rem, 1'b0};
    if (r2 >= {1'b0, den}) begin
      o.rem = DEN_W'(r2 - {1'b0, den});
      o.q   = {s.q[FB-2:0], 1'b1};
    end else begin
      o.rem = r2[DEN_W-1:0];
      o.q   = {s.q[FB-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [RB-1:0] radius_r;
  logic          en;

  logic                  s1_v_r;
  logic signed [DW-1:0]  dx_r, dy_r, ax_r, ay_r;
  logic                  s2_v_r;
  logic signed [P_W-1:0] pxx_r, pyy_r, pbx_r, pby_r, pcx_r, pcy_r;
  logic                  s3_v_r;
  logic [DEN_W-1:0]      den3_r;
  logic signed [B_W-1:0] b3_r;
  logic [CW-1:0]         cabs_r;
  logic [2*RB-1:0]       r2_r;
  logic                  s4_v_r;
  side_t                 sd4_r;
  logic [2*CH-1:0]       chh_r;
  logic [CH+CL-1:0]      chl_r;
  logic [2*CL-1:0]       cll_r;
  logic [2*RB+DH-1:0]    rh_r;
  logic [2*RB+DL-1:0]    rl_r;
  logic                  s5_v_r;
  side_t                 sd5_r;
  logic [CC_W-1:0]       cc_r;
  logic [RR_W-1:0]       rr_r;

  logic                  sq_v_r [0:SQ_W];
  sq_t                   sq_r   [0:SQ_W];
  side_t                 sqs_r  [0:SQ_W];

  logic                  dv_v_r [0:FB];
  dv_t                   dv1_r  [0:FB];
  dv_t                   dv2_r  [0:FB];
  logic [DEN_W-1:0]      dvd_r  [0:FB];
  logic [ST_W-1:0]       dvs_r  [0:FB];

  logic                  out_v_r;
  logic [OUT_W-1:0]      out_d_r;
  logic [ST_W-1:0]       out_s_r;

  logic signed [DW-1:0]   sx, sy, ex, ey, px, py;
  logic signed [P_W:0]    c3_nxt;
  logic signed [B_W:0]    b3_nxt;
  logic [P_W:0]           den3_nxt;
  logic [CH-1:0]          ch;
  logic [CL-1:0]          cl;
  logic [MW-1:0]          cc_ext, rr_ext;
  logic                   neg_nxt;
  side_t                  sd6_nxt;
  sq_t                    sq0_nxt;
  logic signed [N_W-1:0]  n1_nxt, n2_nxt;
  logic [SQ_W-1:0]        root;
  logic [OV_W-1:0]        t1, t2;
  logic [ST_W-1:0]        st_nxt;
  logic [OUT_W-1:0]       od_nxt;

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;
  assign pready    = 1'b1;
  assign prdata    = fsic_pkg::CFG_DW'(radius_r);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_s_r;

  always_comb begin
    sx = DW'($signed(in_tdata[0*CB +: CB]));
    sy = DW'($signed(in_tdata[1*CB +: CB]));
    ex = DW'($signed(in_tdata[2*CB +: CB]));
    ey = DW'($signed(in_tdata[3*CB +: CB]));
    px = DW'($signed(in_tdata[4*CB +: CB]));
    py = DW'($signed(in_tdata[5*CB +: CB]));

    den3_nxt = (P_W + 1)'(pxx_r) + (P_W + 1)'(pyy_r);
    b3_nxt   = (B_W + 1)'(pbx_r) + (B_W + 1)'(pby_r);
    c3_nxt   = (P_W + 1)'(pcx_r) - (P_W + 1)'(pcy_r);

    ch = cabs_r[CW-1:CL];
    cl = cabs_r[CL-1:0];

    cc_ext  = MW'(cc_r);
    rr_ext  = MW'(rr_r);
    neg_nxt = cc_ext > rr_ext;
    sd6_nxt = sd5_r;
    if (sd5_r.den == '0) begin
      sd6_nxt.st = fsic_pkg::ST_ZERO_LEN;
    end else if (neg_nxt) begin
      sd6_nxt.st = fsic_pkg::ST_NONE;
    end else begin
      sd6_nxt.st = fsic_pkg::ST_INTERVAL;
    end
    sq0_nxt.rem = '0;
    sq0_nxt.q   = '0;
    sq0_nxt.rad = neg_nxt ? '0 : RAD_W'(rr_r - RR_W'(cc_r));

    root   = sq_r[SQ_W].q;
    n1_nxt = N_W'(sqs_r[SQ_W].b) - $signed(N_W'(root));
    n2_nxt = N_W'(sqs_r[SQ_W].b) + $signed(N_W'(root));

    t1 = dv1_r[FB].fix ? dv1_r[FB].fval : OV_W'(dv1_r[FB].q);
    t2 = dv2_r[FB].fix ? dv2_r[FB].fval : OV_W'(dv2_r[FB].q);
    od_nxt = '0;
    st_nxt = dvs_r[FB];
    if (dvs_r[FB] == fsic_pkg::ST_INTERVAL) begin
      if (t1 == t2) begin
        st_nxt = fsic_pkg::ST_SINGLE;
      end else begin
        od_nxt = OUT_W'({t2, t1});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= fsic_pkg::RADIUS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == fsic_pkg::REG_RADIUS) begin
      radius_r <= pwdata[RB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i <= SQ_W; i++) begin
        sq_v_r[i] <= 1'b0;
      end
      for (int i = 0; i <= FB; i++) begin
        dv_v_r[i] <= 1'b0;
      end
    end else if (en) begin
      s1_v_r    <= in_tvalid;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      s5_v_r    <= s4_v_r;
      sq_v_r[0] <= s5_v_r;
      for (int i = 0; i < SQ_W; i++) begin
        sq_v_r[i+1] <= sq_v_r[i];
      end
      dv_v_r[0] <= sq_v_r[SQ_W];
      for (int i = 0; i < FB; i++) begin
        dv_v_r[i+1] <= dv_v_r[i];
      end
      out_v_r <= dv_v_r[FB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= ex - sx;
      dy_r <= ey - sy;
      ax_r <= px - sx;
      ay_r <= py - sy;

      pxx_r <= P_W'(dx_r) * P_W'(dx_r);
      pyy_r <= P_W'(dy_r) * P_W'(dy_r);
      pbx_r <= P_W'(ax_r) * P_W'(dx_r);
      pby_r <= P_W'(ay_r) * P_W'(dy_r);
      pcx_r <= P_W'(ax_r) * P_W'(dy_r);
      pcy_r <= P_W'(ay_r) * P_W'(dx_r);

      den3_r <= den3_nxt[DEN_W-1:0];
      b3_r   <= b3_nxt[B_W-1:0];
      cabs_r <= c3_nxt[P_W] ? CW'(-c3_nxt) : CW'(c3_nxt);
      r2_r   <= (2 * RB)'(radius_r) * (2 * RB)'(radius_r);

      sd4_r.b   <= b3_r;
      sd4_r.den <= den3_r;
      sd4_r.st  <= fsic_pkg::ST_INTERVAL;
      chh_r <= (2 * CH)'(ch) * (2 * CH)'(ch);
      chl_r <= (CH + CL)'(ch) * (CH + CL)'(cl);
      cll_r <= (2 * CL)'(cl) * (2 * CL)'(cl);
      rh_r  <= (2 * RB + DH)'(r2_r) * (2 * RB + DH)'(den3_r[DEN_W-1:DL]);
      rl_r  <= (2 * RB + DL)'(r2_r) * (2 * RB + DL)'(den3_r[DL-1:0]);

      sd5_r <= sd4_r;
      cc_r  <= (CC_W'(chh_r) << (2 * CL)) + (CC_W'(chl_r) << (CL + 1)) + CC_W'(cll_r);
      rr_r  <= (RR_W'(rh_r) << DL) + RR_W'(rl_r);

      sq_r[0]  <= sq0_nxt;
      sqs_r[0] <= sd6_nxt;
      for (int i = 0; i < SQ_W; i++) begin
        sq_r[i+1]  <= sq_step(sq_r[i]);
        sqs_r[i+1] <= sqs_r[i];
      end

      dv1_r[0] <= dv_init(n1_nxt, sqs_r[SQ_W].den);
      dv2_r[0] <= dv_init(n2_nxt, sqs_r[SQ_W].den);
      dvd_r[0] <= sqs_r[SQ_W].den;
      dvs_r[0] <= sqs_r[SQ_W].st;
      for (int i = 0; i < FB; i++) begin
        dv1_r[i+1] <= dv1_r[i].fix ? dv1_r[i] : dv_step(dv1_r[i], dvd_r[i]);
        dv2_r[i+1] <= dv2_r[i].fix ? dv2_r[i] : dv_step(dv2_r[i], dvd_r[i]);
        dvd_r[i+1] <= dvd_r[i];
        dvs_r[i+1] <= dvs_r[i];
      end

      out_d_r <= od_nxt;
      out_s_r <= st_nxt;
    end
  end

  a_zero_unless_interval: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_s_r != fsic_pkg::ST_INTERVAL |-> out_d_r == '0)
    else $error("non-interval result carries a non-zero interval");

  a_ordered_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_s_r == fsic_pkg::ST_INTERVAL |->
      out_d_r[OV_W-1:0] < out_d_r[2*OV_W-1:OV_W])
    else $error("interval start is not below interval end");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v_r[0] && sqs_r[0].st == fsic_pkg::ST_INTERVAL |-> sqs_r[0].den != '0)
    else $error("interval status on a zero-length segment");

endmodule
`default_nettype wire
